// ----- src/rfd_pkg.sv -----
// ----------------------------------------------------------------------------
// rfd_pkg
// Shared types and constants for the ring fault diagnosis table.
// ----------------------------------------------------------------------------
`default_nettype none

package rfd_pkg;

   localparam int MAX_NODES = 16;
   localparam int NODE_W    = $clog2(MAX_NODES);
   localparam int CNT_W     = $clog2(MAX_NODES + 1);
   localparam int ENTRY_W   = 1 + NODE_W + 2 * MAX_NODES;

   localparam logic [CNT_W-1:0] NUM_NODES_RESET = CNT_W'(MAX_NODES);
   localparam logic [CNT_W-1:0] MIN_NODES       = CNT_W'(2);

   typedef enum logic [1:0] {
      OP_TEST   = 2'd0,
      OP_FAULT  = 2'd1,
      OP_REPAIR = 2'd2,
      OP_RSVD   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STAT_DONE    = 2'd0,
      STAT_SKIPPED = 2'd1,
      STAT_ALREADY = 2'd2,
      STAT_BADIDX  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      DIAG_UNKNOWN = 2'd0,
      DIAG_OK      = 2'd1,
      DIAG_FAULTY  = 2'd2,
      DIAG_RSVD    = 2'd3
   } diag_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [NODE_W-1:0] node;
   } req_type;

   typedef struct packed {
      logic [1:0]        status_code;
      logic [NODE_W-1:0] tested_node;
      logic              tested_faulty;
      logic              known_fault_valid;
      logic [NODE_W-1:0] known_fault_node;
   } rsp_type;

   // one table word: last-faulty record plus the diagnosis row
   typedef struct packed {
      logic                        lf_valid;
      logic [NODE_W-1:0]           lf_node;
      logic [MAX_NODES-1:0][1:0]   row;
   } entry_type;

   // captured event, handed to the update logic
   typedef struct packed {
      logic [1:0]        opcode;
      logic              bad;
      logic [NODE_W-1:0] tester;
      logic [NODE_W-1:0] succ;
      logic [CNT_W-1:0]  count;
      logic              tester_faulty;
      logic              succ_faulty;
   } ctrl_type;

   // update decision back to the top level
   typedef struct packed {
      logic      wr_en;
      logic      flag_set;
      logic      flag_clr;
      entry_type wr_entry;
      rsp_type   rsp;
   } upd_type;

endpackage

`default_nettype wire

// ----- src/rfd_ram.sv -----
// ----------------------------------------------------------------------------
// rfd_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output      logic [WIDTH-1:0]         rd_data_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output      logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

`default_nettype wire

// ----- src/rfd_update.sv -----
// ----------------------------------------------------------------------------
// rfd_update
// Event decode and row merge: builds the write-back word, flag update and
// result word from the two table words read for an event.
// ----------------------------------------------------------------------------
`default_nettype none

module rfd_update
   import rfd_pkg::*;
(
   input  wire ctrl_type  ctrl,
   input  wire entry_type tester_entry,
   input  wire entry_type succ_entry,
   output      upd_type   upd
);

   entry_type merged;

   // merge successor's known entries inside the active ring, or mark a faulty successor
   always_comb begin
      merged = tester_entry;
      if (ctrl.succ_faulty) begin
         merged.lf_valid        = 1'b1;
         merged.lf_node         = ctrl.succ;
         merged.row[ctrl.succ]  = DIAG_FAULTY;
      end else begin
         if (succ_entry.lf_valid) begin
            merged.lf_valid = 1'b1;
            merged.lf_node  = succ_entry.lf_node;
         end
         for (int j = 0; j < MAX_NODES; j++) begin
            if ((CNT_W'(j) < ctrl.count) && (succ_entry.row[j] != DIAG_UNKNOWN)) begin
               merged.row[j] = succ_entry.row[j];
            end
         end
         merged.row[ctrl.succ] = DIAG_OK;
      end
   end

   always_comb begin
      upd          = '0;
      upd.wr_entry = merged;
      if (ctrl.bad) begin
         upd.rsp.status_code = STAT_BADIDX;
      end else begin
         case (ctrl.opcode)
            OP_FAULT: begin
               if (ctrl.tester_faulty) begin
                  upd.rsp.status_code = STAT_ALREADY;
               end else begin
                  upd.rsp.status_code = STAT_DONE;
                  upd.flag_set        = 1'b1;
               end
            end
            OP_REPAIR: begin
               upd.rsp.status_code = STAT_DONE;
               upd.flag_clr        = 1'b1;
            end
            OP_TEST: begin
               if (ctrl.tester_faulty) begin
                  upd.rsp.status_code = STAT_SKIPPED;
               end else begin
                  upd.wr_en                 = 1'b1;
                  upd.rsp.status_code       = STAT_DONE;
                  upd.rsp.tested_node       = ctrl.succ;
                  upd.rsp.tested_faulty     = ctrl.succ_faulty;
                  upd.rsp.known_fault_valid = merged.lf_valid;
                  upd.rsp.known_fault_node  = merged.lf_node;
               end
            end
            default: begin
               upd.rsp.status_code = STAT_BADIDX;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- src/ring_fault_diagnosis_table_core.sv -----
// ----------------------------------------------------------------------------
// ring_fault_diagnosis_table_core
// Ring fault diagnosis table: fault flags, per-node diagnosis rows and
// last-faulty records, updated by test, fault and repair events.
// ----------------------------------------------------------------------------
// The result is strobed from a register loaded in the exec state.
// A new event is not taken while one is in flight; busy is high the cycle after accept,
//   while both table words (tester and successor) come back from the RAM.
// Receiver cannot stall; each result strobe is high for one cycle only.
// Reset (sync, active high): all nodes fault-free, all rows unknown, no
//   last-faulty record, num_nodes = 16. No clearing pass: per-entry valid
//   flops make unwritten table words read as zero.
`default_nettype none

module ring_fault_diagnosis_table_core
   import rfd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   // event word
   input  wire logic             start,
   input  wire req_type          req_data,
   output      logic             busy,
   // result word
   output      logic             rsp_strobe,
   output      rsp_type          rsp_data,
   // config
   input  wire logic             csr_we,
   input  wire logic [CNT_W-1:0] csr_wdata
);

   state_type state_ff, state_in;

   logic [CNT_W-1:0]     num_nodes_ff;
   logic [CNT_W-1:0]     count;            // clamped node count
   logic [MAX_NODES-1:0] flags_ff, flags_in;
   logic [MAX_NODES-1:0] vld_ff, vld_in;   // table word written since reset
   ctrl_type             ctrl_ff, ctrl_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   rsp_type              rsp_ff;

   logic                 accept;
   logic                 exec;
   logic [CNT_W-1:0]     succ_sum;
   logic [NODE_W-1:0]    succ;

   logic [ENTRY_W-1:0]   rd_a, rd_b;
   entry_type            tester_entry, succ_entry;
   upd_type              upd;

   // ---------------------------------------------------------------- config
   always_comb begin
      if (num_nodes_ff < MIN_NODES) begin
         count = MIN_NODES;
      end else if (num_nodes_ff > CNT_W'(MAX_NODES)) begin
         count = CNT_W'(MAX_NODES);
      end else begin
         count = num_nodes_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_nodes_ff <= NUM_NODES_RESET;
      end else if (csr_we) begin
         num_nodes_ff <= csr_wdata;
      end
   end

   // ---------------------------------------------------------------- FSM
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (start) begin
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            state_in = FSM_IDLE;
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_comb begin
      busy = 1'b0;
      exec = 1'b0;
      case (state_ff)
         FSM_IDLE: busy = 1'b0;
         FSM_EXEC: begin
            busy = 1'b1;
            exec = 1'b1;
         end
         default:  busy = 1'b0;
      endcase
   end

   assign accept = start & ~busy;

   // ring successor: wraps at the active count
   assign succ_sum = {1'b0, req_data.node} + CNT_W'(1);
   assign succ     = (succ_sum == count) ? '0 : succ_sum[NODE_W-1:0];

   // capture the event; flags are stable until the end of this event
   always_comb begin
      ctrl_in = ctrl_ff;
      if (accept) begin
         ctrl_in.opcode        = req_data.opcode;
         ctrl_in.bad           = ({1'b0, req_data.node} >= count) ||
                                 (req_data.opcode == OP_RSVD);
         ctrl_in.tester        = req_data.node;
         ctrl_in.succ          = succ;
         ctrl_in.count         = count;
         ctrl_in.tester_faulty = flags_ff[req_data.node];
         ctrl_in.succ_faulty   = flags_ff[succ];
      end
   end

   // ---------------------------------------------------------------- table
   // Both reads issue at the accept edge; write-back lands at the end of the
   // exec cycle, before the next event can be accepted, so no forwarding.
   rfd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_NODES)
   ) u_table (
      .clock     (clock),
      .wr_en     (exec & upd.wr_en),
      .wr_addr   (ctrl_ff.tester),
      .wr_data   (upd.wr_entry),
      .rd_addr_a (req_data.node),
      .rd_data_a (rd_a),
      .rd_addr_b (succ),
      .rd_data_b (rd_b)
   );

   assign tester_entry = vld_ff[ctrl_ff.tester] ? entry_type'(rd_a) : '0;
   assign succ_entry   = vld_ff[ctrl_ff.succ]   ? entry_type'(rd_b) : '0;

   rfd_update u_update (
      .ctrl         (ctrl_ff),
      .tester_entry (tester_entry),
      .succ_entry   (succ_entry),
      .upd          (upd)
   );

   // ---------------------------------------------------------------- state
   always_comb begin
      flags_in      = flags_ff;
      vld_in        = vld_ff;
      rsp_strobe_in = exec;
      if (exec) begin
         if (upd.flag_set) begin
            flags_in[ctrl_ff.tester] = 1'b1;
         end
         if (upd.flag_clr) begin
            flags_in[ctrl_ff.tester] = 1'b0;
         end
         if (upd.wr_en) begin
            vld_in[ctrl_ff.tester] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= FSM_IDLE;
         flags_ff      <= '0;
         vld_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         flags_ff      <= flags_in;
         vld_ff        <= vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      ctrl_ff <= ctrl_in;
      if (exec) begin
         rsp_ff <= upd.rsp;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

`default_nettype wire
